[hw/rtl/hase_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hase_pkg
// Shared types, constants and tables for the successor expansion pipeline.
// ----------------------------------------------------------------------------
package hase_pkg;

    // Default parameter values
    localparam int POS_FRAC_BITS_DEF  = 16;
    localparam int NUM_DIRECTIONS_DEF = 3;

    // CORDIC geometry
    localparam int CORDIC_ITERS = 16;
    localparam int Z_W          = 20;
    localparam int V_W          = 34;
    localparam int PROD_W       = 59;
    localparam int TERM_W       = 34;

    // Heading constants in Q16 radians
    localparam logic [18:0] TWO_PI_Q16        = 19'd411775;
    localparam logic [18:0] PI_Q16            = 19'd205887;
    localparam logic [18:0] HALF_PI_Q16       = 19'd102944;
    localparam logic [18:0] THREE_HALF_PI_Q16 = 19'd308831;
    localparam logic signed [V_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Cost constants
    localparam logic [15:0] BASE_COST_Q16 = 16'd46325;
    localparam logic [11:0] PEN_ROUND     = 12'd2048;

    // Configuration register indexes
    localparam logic [2:0] REG_PEN_TURN = 3'd0;
    localparam logic [2:0] REG_PEN_REV  = 3'd1;
    localparam logic [2:0] REG_PEN_COD  = 3'd2;
    localparam logic [2:0] REG_GRID_W   = 3'd3;
    localparam logic [2:0] REG_GRID_H   = 3'd4;

    // One word travelling down the CORDIC cell chain
    typedef struct packed {
        logic signed [31:0]     x;
        logic signed [31:0]     y;
        logic [18:0]            h;
        logic [31:0]            cost;
        logic [2:0]             parent;
        logic [2:0]             prim;
        logic signed [Z_W-1:0]  z;
        logic signed [V_W-1:0]  cx;
        logic signed [V_W-1:0]  cy;
        logic                   neg;
    } t_cell_data;

    // Configuration register set
    typedef struct packed {
        logic [15:0] pen_turn;
        logic [15:0] pen_rev;
        logic [15:0] pen_cod;
        logic [14:0] grid_w;
        logic [14:0] grid_h;
    } t_cfg;

    // Result word
    typedef struct packed {
        logic signed [31:0] succ_x;
        logic signed [31:0] succ_y;
        logic [18:0]        succ_heading;
        logic [31:0]        succ_cost;
        logic               on_grid;
    } t_result;

    // Arctangent of 2^-i in Q16
    function automatic logic [15:0] atan_q16(input int i);
        logic [15:0] v;
        case (i)
            0:       v = 16'd51472;
            1:       v = 16'd30385;
            2:       v = 16'd16055;
            3:       v = 16'd8150;
            4:       v = 16'd4091;
            5:       v = 16'd2047;
            6:       v = 16'd1024;
            7:       v = 16'd512;
            8:       v = 16'd256;
            9:       v = 16'd128;
            10:      v = 16'd64;
            11:      v = 16'd32;
            12:      v = 16'd16;
            13:      v = 16'd8;
            14:      v = 16'd4;
            15:      v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Value modulo three for a three-bit code
    function automatic logic [1:0] mod3(input logic [2:0] v);
        logic [1:0] r;
        case (v)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Longitudinal step in Q24
    function automatic logic signed [24:0] step_long(input logic [1:0] row);
        logic signed [24:0] v;
        case (row)
            2'd0:    v = 25'sd11859113;
            default: v = 25'sd11831695;
        endcase
        return v;
    endfunction

    // Lateral step in Q24
    function automatic logic signed [24:0] step_lat(input logic [1:0] row);
        logic signed [24:0] v;
        case (row)
            2'd1:    v = -25'sd697753;
            2'd2:    v = 25'sd697753;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // Heading change in Q16
    function automatic logic signed [19:0] step_turn(input logic [1:0] row);
        logic signed [19:0] v;
        case (row)
            2'd1:    v = 20'sd7721;
            2'd2:    v = -20'sd7721;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/hase_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hase_if
// Valid/ready channels for the parent word, the result word and configuration.
// ----------------------------------------------------------------------------
interface hase_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [18:0]        heading;
    logic [31:0]        cost_in;
    logic [2:0]         parent_prim;
    logic [2:0]         prim_index;

    modport source (output valid, pos_x, pos_y, heading, cost_in, parent_prim,
                    prim_index, input ready);
    modport sink (input valid, pos_x, pos_y, heading, cost_in, parent_prim,
                  prim_index, output ready);
endinterface

interface hase_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] succ_x;
    logic signed [31:0] succ_y;
    logic [18:0]        succ_heading;
    logic [31:0]        succ_cost;
    logic               on_grid;

    modport source (output valid, succ_x, succ_y, succ_heading, succ_cost, on_grid,
                    input ready);
    modport sink (input valid, succ_x, succ_y, succ_heading, succ_cost, on_grid,
                  output ready);
endinterface

interface hase_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/hase_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hase_cordic_cell
// One rotation-mode CORDIC iteration; holds one word and hands it on.
// ----------------------------------------------------------------------------
module hase_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  hase_pkg::t_cell_data     i_data,
    output logic                     o_valid,
    output hase_pkg::t_cell_data     o_data
);

    localparam logic signed [hase_pkg::Z_W-1:0] ATAN =
        hase_pkg::Z_W'(hase_pkg::atan_q16(IDX));

    logic                 r_valid;
    hase_pkg::t_cell_data r_data;
    hase_pkg::t_cell_data n_data;
    logic signed [hase_pkg::V_W-1:0] xs;
    logic signed [hase_pkg::V_W-1:0] ys;

    // Micro-rotation towards zero residual angle
    always_comb begin
        xs     = i_data.cy >>> IDX;
        ys     = i_data.cx >>> IDX;
        n_data = i_data;
        if (i_data.z >= 0) begin
            n_data.cx = i_data.cx - xs;
            n_data.cy = i_data.cy + ys;
            n_data.z  = i_data.z - ATAN;
        end else begin
            n_data.cx = i_data.cx + xs;
            n_data.cy = i_data.cy - ys;
            n_data.z  = i_data.z + ATAN;
        end
    end

    // Cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[hw/rtl/hase_post.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hase_post
// Offset products, position update, heading wrap, cost penalties and grid test.
// ----------------------------------------------------------------------------
module hase_post #(
    parameter int POS_FRAC_BITS  = hase_pkg::POS_FRAC_BITS_DEF,
    parameter int NUM_DIRECTIONS = hase_pkg::NUM_DIRECTIONS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  hase_pkg::t_cell_data i_data,
    input  hase_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    output hase_pkg::t_result    o_result
);

    localparam int SH     = 54 - POS_FRAC_BITS;
    localparam int PW     = hase_pkg::PROD_W;
    localparam int TW     = hase_pkg::TERM_W;
    localparam int G_W    = 48;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (SH - 1);
    localparam logic [3:0] ND = 4'(NUM_DIRECTIONS);

    // Stage one: trig sign, products, first penalty
    logic                  r1_valid;
    logic signed [PW-1:0]  r1_lc, r1_ls, r1_ac, r1_as;
    logic signed [31:0]    r1_x, r1_y;
    logic [18:0]           r1_h;
    logic [31:0]           r1_cost;
    logic                  r1_fwd, r1_cod;
    logic [1:0]            r1_row;
    logic [20:0]           r1_inc;

    logic signed [hase_pkg::V_W-1:0] c, s;
    logic                  fwd, pfwd, turn;
    logic [3:0]            rel;
    logic [1:0]            row;
    logic signed [24:0]    lg, lt;
    logic [32:0]           m1;

    always_comb begin
        c    = i_data.neg ? -i_data.cx : i_data.cx;
        s    = i_data.neg ? -i_data.cy : i_data.cy;
        fwd  = {1'b0, i_data.prim} < ND;
        pfwd = {1'b0, i_data.parent} < ND;
        turn = i_data.prim != i_data.parent;
        rel  = fwd ? {1'b0, i_data.prim} : ({1'b0, i_data.prim} - ND);
        row  = hase_pkg::mod3(rel[2:0]);
        lg   = hase_pkg::step_long(row);
        lt   = hase_pkg::step_lat(row);
        m1   = 33'(hase_pkg::BASE_COST_Q16) * 33'(i_cfg.pen_turn)
             + 33'(hase_pkg::PEN_ROUND);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lc   <= PW'(lg) * PW'(c);
            r1_ls   <= PW'(lg) * PW'(s);
            r1_ac   <= PW'(lt) * PW'(c);
            r1_as   <= PW'(lt) * PW'(s);
            r1_x    <= i_data.x;
            r1_y    <= i_data.y;
            r1_h    <= i_data.h;
            r1_cost <= i_data.cost;
            r1_fwd  <= fwd;
            r1_cod  <= turn && (fwd != pfwd);
            r1_row  <= row;
            r1_inc  <= turn ? m1[32:12] : 21'(hase_pkg::BASE_COST_Q16);
        end
    end

    // Stage two: rounding, position sums with saturation, heading wrap, reverse penalty
    logic                  r2_valid;
    logic signed [31:0]    r2_x, r2_y;
    logic [18:0]           r2_h;
    logic [31:0]           r2_cost;
    logic                  r2_cod;
    logic [25:0]           r2_inc;

    logic signed [PW-1:0]  q_lc, q_ls, q_ac, q_as;
    logic signed [TW-1:0]  t_lc, t_ls, t_ac, t_as;
    logic signed [TW+1:0]  sx, sy;
    logic signed [19:0]    nt;
    logic [18:0]           nh;
    logic [37:0]           m2;
    logic signed [31:0]    nx, ny;

    always_comb begin
        q_lc = (r1_lc + RND) >>> SH;
        q_ls = (r1_ls + RND) >>> SH;
        q_ac = (r1_ac + RND) >>> SH;
        q_as = (r1_as + RND) >>> SH;
        t_lc = q_lc[TW-1:0];
        t_ls = q_ls[TW-1:0];
        t_ac = q_ac[TW-1:0];
        t_as = q_as[TW-1:0];
        if (r1_fwd) begin
            sx = (TW+2)'(r1_x) + (TW+2)'(t_lc) - (TW+2)'(t_as);
            sy = (TW+2)'(r1_y) + (TW+2)'(t_ls) + (TW+2)'(t_ac);
            nt = $signed({1'b0, r1_h}) + hase_pkg::step_turn(r1_row);
        end else begin
            sx = (TW+2)'(r1_x) - (TW+2)'(t_lc) - (TW+2)'(t_as);
            sy = (TW+2)'(r1_y) - (TW+2)'(t_ls) + (TW+2)'(t_ac);
            nt = $signed({1'b0, r1_h}) - hase_pkg::step_turn(r1_row);
        end
        // Saturate to signed 32 bits
        if (sx > (TW+2)'(32'sh7FFFFFFF))       nx = 32'sh7FFFFFFF;
        else if (sx < -(TW+2)'(33'sh80000000)) nx = 32'sh80000000;
        else                                   nx = sx[31:0];
        if (sy > (TW+2)'(32'sh7FFFFFFF))       ny = 32'sh7FFFFFFF;
        else if (sy < -(TW+2)'(33'sh80000000)) ny = 32'sh80000000;
        else                                   ny = sy[31:0];
        // Bring heading back into one turn
        if (nt < 0)
            nh = 19'(nt + $signed({1'b0, hase_pkg::TWO_PI_Q16}));
        else if (nt >= $signed({1'b0, hase_pkg::TWO_PI_Q16}))
            nh = 19'(nt - $signed({1'b0, hase_pkg::TWO_PI_Q16}));
        else
            nh = nt[18:0];
        m2 = 38'(r1_inc) * 38'(i_cfg.pen_rev) + 38'(hase_pkg::PEN_ROUND);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x    <= nx;
            r2_y    <= ny;
            r2_h    <= nh;
            r2_cost <= r1_cost;
            r2_cod  <= r1_cod;
            r2_inc  <= r1_fwd ? 26'(r1_inc) : m2[37:12];
        end
    end

    // Stage three: direction change penalty, cost sum and grid test
    logic                  r3_valid;
    hase_pkg::t_result     r3_res;
    logic [41:0]           m3;
    logic [29:0]           inc3;
    logic [32:0]           csum;
    logic [G_W-1:0]        lim_x, lim_y;
    logic                  on;

    always_comb begin
        m3    = 42'(r2_inc) * 42'(i_cfg.pen_cod) + 42'(hase_pkg::PEN_ROUND);
        inc3  = r2_cod ? m3[41:12] : 30'(r2_inc);
        csum  = 33'(r2_cost) + 33'(inc3);
        lim_x = G_W'(i_cfg.grid_w) << POS_FRAC_BITS;
        lim_y = G_W'(i_cfg.grid_h) << POS_FRAC_BITS;
        on    = !r2_x[31] && (G_W'(r2_x) < lim_x)
             && !r2_y[31] && (G_W'(r2_y) < lim_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res.succ_x       <= r2_x;
            r3_res.succ_y       <= r2_y;
            r3_res.succ_heading <= r2_h;
            r3_res.succ_cost    <= csum[32] ? 32'hFFFFFFFF : csum[31:0];
            r3_res.on_grid      <= on;
        end
    end

    // Valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign o_valid  = r3_valid;
    assign o_result = r3_res;

endmodule
`default_nettype wire

[hw/rtl/hybrid_astar_successor_expand.sv]
// Structure: each accepted word passes through 16 CORDIC cells and
// three arithmetic stages, the last being the output register.
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or its word is being taken.
// Reset: synchronous active-low; clears all valid flags and loads the
// configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_astar_successor_expand
// Pose, heading and cost of one successor per parent word.
// ----------------------------------------------------------------------------
module hybrid_astar_successor_expand #(
    parameter int POS_FRAC_BITS  = hase_pkg::POS_FRAC_BITS_DEF,
    parameter int NUM_DIRECTIONS = hase_pkg::NUM_DIRECTIONS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hase_in_if.sink          i_in,
    hase_out_if.source       o_out,
    hase_cfg_if.sink         i_cfg
);

    localparam int N = hase_pkg::CORDIC_ITERS;

    hase_pkg::t_cfg       r_cfg;
    logic                 en;
    logic                 out_valid;
    hase_pkg::t_result    out_res;
    hase_pkg::t_cell_data pre;
    hase_pkg::t_cell_data cell_d [N+1];
    logic                 cell_v [N+1];
    logic [18:0]          hw;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pen_turn <= 16'd4301;
            r_cfg.pen_rev  <= 16'd8192;
            r_cfg.pen_cod  <= 16'd8192;
            r_cfg.grid_w   <= 15'd1024;
            r_cfg.grid_h   <= 15'd1024;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hase_pkg::REG_PEN_TURN: r_cfg.pen_turn <= i_cfg.data;
                hase_pkg::REG_PEN_REV:  r_cfg.pen_rev  <= i_cfg.data;
                hase_pkg::REG_PEN_COD:  r_cfg.pen_cod  <= i_cfg.data;
                hase_pkg::REG_GRID_W:   r_cfg.grid_w   <= i_cfg.data[14:0];
                hase_pkg::REG_GRID_H:   r_cfg.grid_h   <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances when the output register can take a new word
    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    // Heading reduction and quadrant folding into the CORDIC range
    always_comb begin
        hw = (i_in.heading >= hase_pkg::TWO_PI_Q16) ?
             (i_in.heading - hase_pkg::TWO_PI_Q16) : i_in.heading;
        pre.x      = i_in.pos_x;
        pre.y      = i_in.pos_y;
        pre.h      = hw;
        pre.cost   = i_in.cost_in;
        pre.parent = i_in.parent_prim;
        pre.prim   = i_in.prim_index;
        pre.cx     = hase_pkg::CORDIC_GAIN_Q30;
        pre.cy     = '0;
        if (hw <= hase_pkg::HALF_PI_Q16) begin
            pre.z   = hase_pkg::Z_W'(hw);
            pre.neg = 1'b0;
        end else if (hw < hase_pkg::THREE_HALF_PI_Q16) begin
            pre.z   = hase_pkg::Z_W'(hw) - hase_pkg::Z_W'(hase_pkg::PI_Q16);
            pre.neg = 1'b1;
        end else begin
            pre.z   = hase_pkg::Z_W'(hw) - hase_pkg::Z_W'(hase_pkg::TWO_PI_Q16);
            pre.neg = 1'b0;
        end
    end

    assign cell_d[0] = pre;
    assign cell_v[0] = i_in.valid;

    // Chain of CORDIC cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        hase_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cell_v[g]),
            .i_data  (cell_d[g]),
            .o_valid (cell_v[g+1]),
            .o_data  (cell_d[g+1])
        );
    end

    // Position, heading, cost and grid stages
    hase_post #(
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .NUM_DIRECTIONS (NUM_DIRECTIONS)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cell_v[N]),
        .i_data   (cell_d[N]),
        .i_cfg    (r_cfg),
        .o_valid  (out_valid),
        .o_result (out_res)
    );

    assign o_out.valid        = out_valid;
    assign o_out.succ_x       = out_res.succ_x;
    assign o_out.succ_y       = out_res.succ_y;
    assign o_out.succ_heading = out_res.succ_heading;
    assign o_out.succ_cost    = out_res.succ_cost;
    assign o_out.on_grid      = out_res.on_grid;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the successor expansion pipeline. Parent words are
// streamed in bursts under a stalling receiver. Each accepted word is
// predicted by a bit-true model of the CORDIC rotation, position update,
// heading wrap, cost penalties and grid test. Results are checked in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int       POS_FRAC   = 16;
    localparam int       DIRS       = 3;
    localparam longint   FULL_TURN  = 411775;
    localparam longint   HALF_TURN  = 205887;
    localparam longint   QUARTER    = 102944;
    localparam longint   THREE_QTR  = 308831;
    localparam longint   GAIN       = 652032874;
    localparam longint   STEP_COST  = 46325;
    localparam int       PIPE_DEPTH = 19;

    // One parent word as offered to the block
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [18:0] heading;
        logic [31:0] cost;
        logic [2:0]  parent;
        logic [2:0]  prim;
    } t_parent;

    logic i_clk;
    logic i_rst_n;

    hase_in_if  in_ch ();
    hase_out_if out_ch ();
    hase_cfg_if cfg_ch ();

    hybrid_astar_successor_expand dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_parent           pending_parents[$];
    hase_pkg::t_result expected_successors[$];
    hase_pkg::t_cfg    shadow_cfg;
    int                error_count;
    bit                hold_sender;
    int                burst_left;
    int                gap_left;
    int                stall_cycle;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Bit-true expansion of one parent word under the current register set.
    function automatic hase_pkg::t_result expand_parent(input t_parent p,
                                                        input hase_pkg::t_cfg cfg);
        longint   atan_tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};
        longint   long_tab[3] = '{11859113, 11831695, 11831695};
        longint   lat_tab[3]  = '{0, -697753, 697753};
        longint   turn_tab[3] = '{0, 7721, -7721};
        longint   h, z, cx, cy, xs, ys, c, s, lc, ls, ac, as_t, nx, ny, nt;
        longint   px, py, half;
        longint unsigned inc, total;
        bit       neg, fwd, parent_fwd;
        int       row, sh;
        hase_pkg::t_result r;
        sh   = 54 - POS_FRAC;
        half = longint'(1) <<< (sh - 1);
        px   = longint'($signed(p.pos_x));
        py   = longint'($signed(p.pos_y));
        h    = longint'(p.heading) % FULL_TURN;
        fwd        = p.prim < DIRS;
        parent_fwd = p.parent < DIRS;
        row  = (fwd ? int'(p.prim) : int'(p.prim) - DIRS) % 3;
        // Fold the heading into the CORDIC convergence range.
        neg = 1'b0;
        if (h <= QUARTER) begin
            z = h;
        end else if (h < THREE_QTR) begin
            z   = h - HALF_TURN;
            neg = 1'b1;
        end else begin
            z = h - FULL_TURN;
        end
        cx = GAIN;
        cy = 0;
        for (int i = 0; i < 16; i++) begin
            xs = cy >>> i;
            ys = cx >>> i;
            if (z >= 0) begin
                cx -= xs;
                cy += ys;
                z  -= atan_tab[i];
            end else begin
                cx += xs;
                cy -= ys;
                z  += atan_tab[i];
            end
        end
        c = neg ? -cx : cx;
        s = neg ? -cy : cy;
        lc   = (long_tab[row] * c + half) >>> sh;
        ls   = (long_tab[row] * s + half) >>> sh;
        ac   = (lat_tab[row] * c + half) >>> sh;
        as_t = (lat_tab[row] * s + half) >>> sh;
        if (fwd) begin
            nx = px + lc - as_t;
            ny = py + ls + ac;
            nt = h + turn_tab[row];
        end else begin
            nx = px - lc - as_t;
            ny = py - ls + ac;
            nt = h - turn_tab[row];
        end
        nt = nt % FULL_TURN;
        if (nt < 0) nt += FULL_TURN;
        if (nx > 64'sd2147483647) nx = 64'sd2147483647;
        if (nx < -64'sd2147483648) nx = -64'sd2147483648;
        if (ny > 64'sd2147483647) ny = 64'sd2147483647;
        if (ny < -64'sd2147483648) ny = -64'sd2147483648;
        // Penalties are applied one at a time, each rounded back to Q16.
        inc = STEP_COST;
        if (p.prim != p.parent) begin
            inc = (inc * cfg.pen_turn + 2048) >> 12;
            if (!fwd) inc = (inc * cfg.pen_rev + 2048) >> 12;
            if (fwd != parent_fwd) inc = (inc * cfg.pen_cod + 2048) >> 12;
        end else if (!fwd) begin
            inc = (inc * cfg.pen_rev + 2048) >> 12;
        end
        total = longint'(p.cost) + inc;
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        r.succ_x       = nx[31:0];
        r.succ_y       = ny[31:0];
        r.succ_heading = nt[18:0];
        r.succ_cost    = total[31:0];
        r.on_grid      = nx >= 0 && nx < (longint'(cfg.grid_w) <<< POS_FRAC) &&
                         ny >= 0 && ny < (longint'(cfg.grid_h) <<< POS_FRAC);
        return r;
    endfunction

    // Sender: bursts of words from the pending queue with random gaps.
    always @(posedge i_clk) begin
        t_parent p;
        logic    next_valid;
        if (in_ch.valid && in_ch.ready) begin
            p.pos_x   = in_ch.pos_x;
            p.pos_y   = in_ch.pos_y;
            p.heading = in_ch.heading;
            p.cost    = in_ch.cost_in;
            p.parent  = in_ch.parent_prim;
            p.prim    = in_ch.prim_index;
            expected_successors.push_back(expand_parent(p, shadow_cfg));
        end
        next_valid = 1'b0;
        if (in_ch.valid && !in_ch.ready) begin
            next_valid = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (i_rst_n && !hold_sender && pending_parents.size() > 0) begin
            p = pending_parents.pop_front();
            in_ch.pos_x       <= p.pos_x;
            in_ch.pos_y       <= p.pos_y;
            in_ch.heading     <= p.heading;
            in_ch.cost_in     <= p.cost;
            in_ch.parent_prim <= p.parent;
            in_ch.prim_index  <= p.prim;
            next_valid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        in_ch.valid <= next_valid;
    end

    // Receiver: alternates between always ready, random stalls and a fixed beat.
    always @(posedge i_clk) begin
        logic next_ready;
        stall_cycle++;
        case ((stall_cycle / 97) % 4)
            0:       next_ready = 1'b1;
            1:       next_ready = $urandom_range(0, 1) != 0;
            2:       next_ready = (stall_cycle % 5) != 0;
            default: next_ready = $urandom_range(0, 7) != 0;
        endcase
        out_ch.ready <= next_ready;
    end

    // Result checker: in-order comparison against the oldest prediction.
    always @(posedge i_clk) begin
        hase_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_successors.size() == 0) begin
                $display("%0t: unexpected result word x=%h y=%h", $time,
                         out_ch.succ_x, out_ch.succ_y);
                error_count++;
            end else begin
                want = expected_successors.pop_front();
                if (out_ch.succ_x !== want.succ_x) begin
                    $display("%0t: succ_x expected %h actual %h", $time,
                             want.succ_x, out_ch.succ_x);
                    error_count++;
                end
                if (out_ch.succ_y !== want.succ_y) begin
                    $display("%0t: succ_y expected %h actual %h", $time,
                             want.succ_y, out_ch.succ_y);
                    error_count++;
                end
                if (out_ch.succ_heading !== want.succ_heading) begin
                    $display("%0t: succ_heading expected %0d actual %0d", $time,
                             want.succ_heading, out_ch.succ_heading);
                    error_count++;
                end
                if (out_ch.succ_cost !== want.succ_cost) begin
                    $display("%0t: succ_cost expected %h actual %h", $time,
                             want.succ_cost, out_ch.succ_cost);
                    error_count++;
                end
                if (out_ch.on_grid !== want.on_grid) begin
                    $display("%0t: on_grid expected %b actual %b", $time,
                             want.on_grid, out_ch.on_grid);
                    error_count++;
                end
            end
        end
    end

    // Writes one register and mirrors it once the word has been taken.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            hase_pkg::REG_PEN_TURN: shadow_cfg.pen_turn = value;
            hase_pkg::REG_PEN_REV:  shadow_cfg.pen_rev  = value;
            hase_pkg::REG_PEN_COD:  shadow_cfg.pen_cod  = value;
            hase_pkg::REG_GRID_W:   shadow_cfg.grid_w   = value[14:0];
            hase_pkg::REG_GRID_H:   shadow_cfg.grid_h   = value[14:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_config(input logic [15:0] pt, input logic [15:0] pr,
                               input logic [15:0] pc, input logic [14:0] gw,
                               input logic [14:0] gh);
        write_reg(hase_pkg::REG_PEN_TURN, pt);
        write_reg(hase_pkg::REG_PEN_REV, pr);
        write_reg(hase_pkg::REG_PEN_COD, pc);
        write_reg(hase_pkg::REG_GRID_W, {1'b0, gw});
        write_reg(hase_pkg::REG_GRID_H, {1'b0, gh});
    endtask

    // Waits until the pipeline has drained, then idles for longer than its depth.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_parents.size() != 0 || expected_successors.size() != 0 ||
               in_ch.valid);
        repeat (PIPE_DEPTH + 6) @(posedge i_clk);
    endtask

    // Position mostly around the grid, sometimes anywhere or near the limits.
    function automatic logic [31:0] pick_pos(input logic [14:0] grid);
        longint span;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
            2:       return 32'h8000_0000 + $urandom_range(0, 1 << 20);
            default: begin
                span = (longint'(grid) + 2) <<< POS_FRAC;
                return 32'(longint'($urandom_range(0, 32'(span))) - 65536);
            end
        endcase
    endfunction

    function automatic t_parent random_parent();
        t_parent p;
        p.pos_x   = pick_pos(shadow_cfg.grid_w);
        p.pos_y   = pick_pos(shadow_cfg.grid_h);
        p.heading = ($urandom_range(0, 9) == 0) ? 19'($urandom)
                                                : 19'($urandom_range(0, 411774));
        p.cost    = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1 << 18)
                                                : $urandom;
        p.parent  = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
        p.prim    = ($urandom_range(0, 3) == 0) ? p.parent
                  : ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
        return p;
    endfunction

    task automatic directed_parent(input logic [31:0] x, input logic [31:0] y,
                                   input logic [18:0] h, input logic [31:0] cost,
                                   input logic [2:0] parent, input logic [2:0] prim);
        t_parent p;
        p.pos_x   = x;
        p.pos_y   = y;
        p.heading = h;
        p.cost    = cost;
        p.parent  = parent;
        p.prim    = prim;
        pending_parents.push_back(p);
    endtask

    // Main sequence: reset, directed words, then random phases per setting.
    initial begin
        in_ch.valid       = 1'b0;
        in_ch.pos_x       = '0;
        in_ch.pos_y       = '0;
        in_ch.heading     = '0;
        in_ch.cost_in     = '0;
        in_ch.parent_prim = '0;
        in_ch.prim_index  = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        error_count = 0;
        hold_sender = 1'b0;
        burst_left  = 1;
        gap_left    = 0;
        stall_cycle = 0;
        shadow_cfg  = '{16'd4301, 16'd8192, 16'd8192, 15'd1024, 15'd1024};
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: every primitive, quadrant edges, saturation cases.
        for (int k = 0; k < 8; k++) begin
            directed_parent(32'h0010_0000, 32'h0020_0000, 19'(k * 51472),
                            32'h0001_0000, 3'((k + 1) % 8), 3'(k));
        end
        directed_parent(32'h0, 32'h0, 19'd102944, 32'h0, 3'd0, 3'd0);
        directed_parent(32'h0, 32'h0, 19'd102945, 32'h0, 3'd1, 3'd1);
        directed_parent(32'h0, 32'h0, 19'd308830, 32'h0, 3'd3, 3'd3);
        directed_parent(32'h0, 32'h0, 19'd308831, 32'h0, 3'd4, 3'd1);
        directed_parent(32'h0, 32'h0, 19'd411774, 32'h0, 3'd2, 3'd5);
        directed_parent(32'h0, 32'h0, 19'd411775, 32'h0, 3'd5, 3'd2);
        directed_parent(32'h0, 32'h0, 19'h7FFFF, 32'h0, 3'd6, 3'd7);
        directed_parent(32'h7FFF_FFFF, 32'h7FFF_FFFF, 19'd0, 32'hFFFF_FFFF, 3'd0, 3'd1);
        directed_parent(32'h8000_0000, 32'h8000_0000, 19'd205887, 32'hFFFF_FFFF, 3'd3, 3'd4);
        directed_parent(32'h7FFF_FFFF, 32'h8000_0000, 19'd0, 32'hFFFF_0000, 3'd0, 3'd3);
        directed_parent(32'h8000_0000, 32'h7FFF_FFFF, 19'd205887, 32'h0, 3'd7, 3'd0);
        directed_parent(32'h03FF_FFFF, 32'h03FF_FFFF, 19'd0, 32'h0, 3'd0, 3'd0);
        directed_parent(32'hFFFF_FFFF, 32'h0, 19'd0, 32'h0, 3'd0, 3'd0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
                1: load_config(16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
                2: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                               15'($urandom_range(1, 64)), 15'($urandom_range(1, 64)));
                3: load_config(16'd4096, 16'd8192, 16'd12288, 15'd1, 15'd3);
                4: load_config(16'd4301, 16'd8192, 16'd8192, 15'd1024, 15'd1024);
                default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                                     15'($urandom), 15'($urandom));
            endcase
            for (int n = 0; n < 225; n++) pending_parents.push_back(random_parent());
            // Once per phase the sender holds off until the pipeline is empty.
            while (pending_parents.size() > 110) @(posedge i_clk);
            @(negedge i_clk);
            hold_sender = 1'b1;
            while (expected_successors.size() != 0 || in_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
            hold_sender = 1'b0;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
